/* design/assert_macros.svh */
// Assertion macros shared by the scheduler RTL.
// Uses the clk and rst_n names of the module that expands them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset
`define TPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tick_priority_scheduler assertion failed");
// Check a property on every clock edge, reset included
`define TPS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tick_priority_scheduler assertion failed");
`else
`define TPS_ASSERT(lbl, prop)
`define TPS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* design/tps_pkg.sv */
// Package for the tick priority scheduler: item kinds and field widths.
// No dependencies.
`timescale 1ns / 1ps
package tps_pkg;

  // Field widths of the input and result items
  localparam int KIND_W  = 2;
  localparam int PROC_W  = 3;
  localparam int PVAL_W  = 8;
  localparam int TICKS_W = 8;
  localparam int COUNT_W = 32;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BLOCK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESCHED  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_PRIORITY = 2'd3;

  typedef logic [KIND_W-1:0] kind_t;

endpackage

/* design/tick_priority_scheduler_top.sv */
// Tick priority scheduler: process table, tick counter and reschedule sequencer.
// Depends on tps_pkg and assert_macros.svh.
//
// Usage:
//   Input channel in_*: one item per transfer (tick, set blocked flag,
//   reschedule request, write priority). in_stall is high while an item is
//   being worked on; the next item is taken once the result is loaded.
//   Result channel out_*: one result per item, held in an output register
//   until the receiver drops out_stall. A stalled result holds the
//   sequencer in its final step, so no further item is taken meanwhile.
//   A flag or priority write goes through S_OUT_RD and S_OUT to the result; a
//   tick first takes one from the running budget in S_TICK. A reschedule scans
//   the table through one comparator, one entry per cycle over a single read
//   port with registered data, in up to three passes (select, refill, select
//   again). Reset clears the tick count, the current process, the blocked
//   flags and marks every table entry as zero through one valid bit per entry.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tick_priority_scheduler_top #(
  parameter int NUM_PROCS = 8,
  parameter int TICK_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tps_pkg::kind_t            in_kind,
  input  logic [tps_pkg::PROC_W-1:0] in_process,
  input  logic                      in_blocked,
  input  logic [tps_pkg::PVAL_W-1:0] in_priority_value,
  input  logic                      in_nested,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [tps_pkg::PROC_W-1:0] out_running_process,
  output logic [tps_pkg::TICKS_W-1:0] out_running_ticks,
  output logic                      out_switched,
  output logic                      out_idle,
  output logic [tps_pkg::COUNT_W-1:0] out_tick_count
);
  import tps_pkg::*;

  localparam int PIDX_W = $clog2(NUM_PROCS);
  localparam int CNT_W  = $clog2(NUM_PROCS + 1);
  localparam int ENT_W  = 2 * TICK_BITS;
  localparam logic [31:0] BUDGET_MAX = 32'((33'd1 << TICK_BITS) - 33'd1);
  localparam logic [CNT_W-1:0] PROCS_C = CNT_W'(NUM_PROCS);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TICK   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_REFILL = 3'd3;
  localparam logic [2:0] S_OUT_RD = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  // Table memory: {prio, budget} per entry, valid bit per entry
  logic [ENT_W-1:0]     mem [NUM_PROCS];
  logic [ENT_W-1:0]     rd_data_r;
  logic                 rd_vld_r;
  logic [NUM_PROCS-1:0] valid_r, valid_nxt;
  logic                 mem_we;
  logic [PIDX_W-1:0]    mem_waddr, mem_raddr;
  logic [ENT_W-1:0]     mem_wdata;

  // Control and scan state
  logic [2:0]           state_r, state_nxt;
  logic [NUM_PROCS-1:0] blk_r, blk_nxt;
  logic [PIDX_W-1:0]    current_r, current_nxt;
  logic [COUNT_W-1:0]   ticks_r, ticks_nxt;
  logic                 nested_r, nested_nxt;
  logic                 switched_r, switched_nxt;
  logic                 idle_r, idle_nxt;
  logic                 pass_r, pass_nxt;
  logic [CNT_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [PIDX_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic [TICK_BITS-1:0] best_r, best_nxt;
  logic [PIDX_W-1:0]    who_r, who_nxt;
  logic                 found_r, found_nxt;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [PROC_W-1:0]    out_proc_r;
  logic [TICKS_W-1:0]   out_ticks_r;
  logic                 out_switched_r, out_idle_r;
  logic [COUNT_W-1:0]   out_count_r;
  logic                 out_load;

  // Helpers
  logic                 in_xfer;
  logic                 proc_ok;
  logic [PIDX_W-1:0]    proc_idx;
  logic [31:0]          pval_ext, pval_sat;
  logic [TICK_BITS-1:0] pval_t;
  logic [TICK_BITS-1:0] rd_budget, rd_prio, dec_budget;
  logic                 issue;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign proc_ok  = (32'(in_process) < 32'(NUM_PROCS));
  assign proc_idx = PIDX_W'(in_process);
  assign pval_ext = 32'(in_priority_value);
  assign pval_sat = (pval_ext > BUDGET_MAX) ? BUDGET_MAX : pval_ext;
  assign pval_t   = TICK_BITS'(pval_sat);

  // Read data, with never-written entries reading as zero
  assign rd_budget  = rd_vld_r ? rd_data_r[TICK_BITS-1:0] : '0;
  assign rd_prio    = rd_vld_r ? rd_data_r[ENT_W-1:TICK_BITS] : '0;
  assign dec_budget = (rd_budget != '0) ? rd_budget - 1'b1 : '0;
  assign issue      = (scan_idx_r < PROCS_C);
  assign out_load   = !out_valid_r || !out_stall;

  // Sequencer and shared compare unit
  always_comb begin
    state_nxt     = state_r;
    blk_nxt       = blk_r;
    current_nxt   = current_r;
    ticks_nxt     = ticks_r;
    nested_nxt    = nested_r;
    switched_nxt  = switched_r;
    idle_nxt      = idle_r;
    pass_nxt      = pass_r;
    scan_idx_nxt  = scan_idx_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    best_nxt      = best_r;
    who_nxt       = who_r;
    found_nxt     = found_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr     = current_r;
    mem_wdata     = '0;
    mem_raddr     = current_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          nested_nxt   = in_nested;
          switched_nxt = 1'b0;
          idle_nxt     = 1'b0;
          pass_nxt     = 1'b0;
          scan_idx_nxt = '0;
          best_nxt     = '0;
          found_nxt    = 1'b0;
          case (in_kind)
            KIND_TICK: begin
              ticks_nxt = ticks_r + 1'b1;
              state_nxt = S_TICK;
            end
            KIND_BLOCK: begin
              if (proc_ok) blk_nxt[proc_idx] = in_blocked;
              state_nxt = S_OUT_RD;
            end
            KIND_RESCHED: begin
              switched_nxt = 1'b1;
              state_nxt    = S_SCAN;
            end
            default: begin
              if (proc_ok) begin
                mem_we              = 1'b1;
                mem_waddr           = proc_idx;
                mem_wdata           = {pval_t, pval_t};
                valid_nxt[proc_idx] = 1'b1;
              end
              state_nxt = S_OUT_RD;
            end
          endcase
        end
      end
      S_TICK: begin
        // Take one from the running budget, saturating at zero
        mem_we               = 1'b1;
        mem_wdata            = {rd_prio, dec_budget};
        valid_nxt[current_r] = 1'b1;
        if (!nested_r && dec_budget == '0) begin
          switched_nxt = 1'b1;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_OUT_RD;
        end
      end
      S_SCAN: begin
        mem_raddr    = PIDX_W'(scan_idx_r);
        pend_nxt     = issue;
        pend_idx_nxt = PIDX_W'(scan_idx_r);
        if (issue) scan_idx_nxt = scan_idx_r + 1'b1;
        if (pend_r && !blk_r[pend_idx_r] && rd_budget > best_r) begin
          best_nxt  = rd_budget;
          who_nxt   = pend_idx_r;
          found_nxt = 1'b1;
        end
        if (!issue && !pend_r) begin
          scan_idx_nxt = '0;
          if (found_r) begin
            current_nxt = who_r;
            state_nxt   = S_OUT_RD;
          end else if (!pass_r) begin
            state_nxt = S_REFILL;
          end else begin
            idle_nxt  = 1'b1;
            state_nxt = S_OUT_RD;
          end
        end
      end
      S_REFILL: begin
        // Reload each runnable budget from its priority
        mem_raddr    = PIDX_W'(scan_idx_r);
        pend_nxt     = issue;
        pend_idx_nxt = PIDX_W'(scan_idx_r);
        if (issue) scan_idx_nxt = scan_idx_r + 1'b1;
        if (pend_r && !blk_r[pend_idx_r]) begin
          mem_we                = 1'b1;
          mem_waddr             = pend_idx_r;
          mem_wdata             = {rd_prio, rd_prio};
          valid_nxt[pend_idx_r] = 1'b1;
        end
        if (!issue && !pend_r) begin
          scan_idx_nxt = '0;
          pass_nxt     = 1'b1;
          best_nxt     = '0;
          found_nxt    = 1'b0;
          state_nxt    = S_SCAN;
        end
      end
      S_OUT_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Table memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[mem_raddr];
    rd_vld_r  <= valid_r[mem_raddr];
  end

  // Hold the result when loaded
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_load) begin
      out_proc_r     <= PROC_W'(current_r);
      out_ticks_r    <= TICKS_W'(rd_budget);
      out_switched_r <= switched_r;
      out_idle_r     <= idle_r;
      out_count_r    <= ticks_r;
    end
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      blk_r       <= '0;
      current_r   <= '0;
      ticks_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      scan_idx_r  <= '0;
      found_r     <= 1'b0;
      pass_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      blk_r       <= blk_nxt;
      current_r   <= current_nxt;
      ticks_r     <= ticks_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      scan_idx_r  <= scan_idx_nxt;
      found_r     <= found_nxt;
      pass_r      <= pass_nxt;
    end
  end

  // Scan and result bookkeeping
  always_ff @(posedge clk) begin
    nested_r   <= nested_nxt;
    switched_r <= switched_nxt;
    idle_r     <= idle_nxt;
    pend_idx_r <= pend_idx_nxt;
    best_r     <= best_nxt;
    who_r      <= who_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_running_process = out_proc_r;
  assign out_running_ticks   = out_ticks_r;
  assign out_switched        = out_switched_r;
  assign out_idle            = out_idle_r;
  assign out_tick_count      = out_count_r;

  `TPS_ASSERT(a_xfer_leaves_idle, in_xfer |=> state_r != S_IDLE)
  `TPS_ASSERT(a_result_from_out, $rose(out_valid_r) |-> $past(state_r) == S_OUT)
  `TPS_ASSERT(a_idle_needs_switch, out_valid_r |-> (!out_idle_r || out_switched_r))
  `TPS_ASSERT(a_scan_bound, scan_idx_r <= PROCS_C)
  `TPS_ASSERT(a_found_has_budget, (state_r == S_SCAN && found_r) |-> best_r != '0)

endmodule

/* tb/tps_checker.sv */
// Scoreboard for the tick priority scheduler: watches both channels, predicts each result.
// Depends on tps_pkg; instantiated beside the block by tb_top.
`timescale 1ns / 1ps
module tps_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  tps_pkg::kind_t               in_kind,
  input  logic [tps_pkg::PROC_W-1:0]   in_process,
  input  logic                         in_blocked,
  input  logic [tps_pkg::PVAL_W-1:0]   in_priority_value,
  input  logic                         in_nested,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [tps_pkg::PROC_W-1:0]   out_running_process,
  input  logic [tps_pkg::TICKS_W-1:0]  out_running_ticks,
  input  logic                         out_switched,
  input  logic                         out_idle,
  input  logic [tps_pkg::COUNT_W-1:0]  out_tick_count,
  output int                           mismatch_count,
  output int                           results_owed
);
  import tps_pkg::*;

  localparam int NPROC = 1 << PROC_W;

  typedef struct packed {
    logic [PROC_W-1:0]  proc;
    logic [TICKS_W-1:0] ticks;
    logic               switched;
    logic               idle;
    logic [COUNT_W-1:0] count;
  } sched_result_t;

  // Shadow copy of the process table
  logic [TICKS_W-1:0] budget_tbl [NPROC];
  logic [TICKS_W-1:0] prio_tbl   [NPROC];
  logic               blk_tbl    [NPROC];
  logic [PROC_W-1:0]  cur_proc;
  logic [COUNT_W-1:0] tick_total;

  sched_result_t expected_results [$];
  sched_result_t want_r;
  logic          bad;

  // Lowest index holding the largest nonzero runnable budget, NPROC if none
  function automatic int pick_richest();
    int who;
    logic [TICKS_W-1:0] best;
    who  = NPROC;
    best = '0;
    for (int i = 0; i < NPROC; i++)
      if (!blk_tbl[i] && budget_tbl[i] > best) begin
        best = budget_tbl[i];
        who  = i;
      end
    return who;
  endfunction

  // Select, refill runnable budgets from priority if all spent, select again.
  // Returns 1 when nothing can run; the current process is then kept.
  function automatic logic reschedule_table();
    int who;
    who = pick_richest();
    if (who >= NPROC) begin
      for (int i = 0; i < NPROC; i++)
        if (!blk_tbl[i]) budget_tbl[i] = prio_tbl[i];
      who = pick_richest();
    end
    if (who >= NPROC) return 1'b1;
    cur_proc = who[PROC_W-1:0];
    return 1'b0;
  endfunction

  // Advance the shadow table by one item and queue the result it yields
  task automatic predict_schedule(kind_t k, logic [PROC_W-1:0] p, logic b,
                                  logic [PVAL_W-1:0] v, logic n);
    sched_result_t r;
    r = '0;
    case (k)
      KIND_TICK: begin
        tick_total = tick_total + 1'b1;
        if (budget_tbl[cur_proc] != 0) budget_tbl[cur_proc] = budget_tbl[cur_proc] - 1'b1;
        if (!n && budget_tbl[cur_proc] == 0) begin
          r.switched = 1'b1;
          r.idle     = reschedule_table();
        end
      end
      KIND_BLOCK: blk_tbl[p] = b;
      KIND_RESCHED: begin
        r.switched = 1'b1;
        r.idle     = reschedule_table();
      end
      default: begin
        prio_tbl[p]   = v;
        budget_tbl[p] = v;
      end
    endcase
    r.proc  = cur_proc;
    r.ticks = budget_tbl[cur_proc];
    r.count = tick_total;
    expected_results.push_back(r);
  endtask

  function automatic logic field_differs(string fname, logic [31:0] want, logic [31:0] got);
    if (want === got) return 1'b0;
    $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NPROC; i++) begin
        budget_tbl[i] = '0;
        prio_tbl[i]   = '0;
        blk_tbl[i]    = 1'b0;
      end
      cur_proc       = '0;
      tick_total     = '0;
      mismatch_count = 0;
      expected_results.delete();
      results_owed <= 0;
    end else begin
      // Compare the result transfer with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, process %0d ticks %0d count %0d",
                   $time, out_running_process, out_running_ticks, out_tick_count);
          mismatch_count++;
        end else begin
          want_r = expected_results.pop_front();
          bad = field_differs("running_process", 32'(want_r.proc), 32'(out_running_process))
              | field_differs("running_ticks", 32'(want_r.ticks), 32'(out_running_ticks))
              | field_differs("switched", 32'(want_r.switched), 32'(out_switched))
              | field_differs("idle", 32'(want_r.idle), 32'(out_idle))
              | field_differs("tick_count", want_r.count, out_tick_count);
          if (bad) mismatch_count++;
        end
      end
      // Predict on every input transfer
      if (in_valid && !in_stall)
        predict_schedule(in_kind, in_process, in_blocked, in_priority_value, in_nested);
      results_owed <= expected_results.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Testbench top for the tick priority scheduler: clock, reset, stimulus and verdict.
// Depends on tps_pkg, tick_priority_scheduler_top and tps_checker.
`timescale 1ns / 1ps
module tb_top;
  import tps_pkg::*;

  localparam int LONG_HOLD   = 300;
  localparam int SETTLE_CYC  = 40;
  localparam int PHASE_ITEMS = 460;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  kind_t               in_kind;
  logic [PROC_W-1:0]   in_process;
  logic                in_blocked;
  logic [PVAL_W-1:0]   in_priority_value;
  logic                in_nested;
  logic                out_valid;
  logic                out_stall;
  logic [PROC_W-1:0]   out_running_process;
  logic [TICKS_W-1:0]  out_running_ticks;
  logic                out_switched;
  logic                out_idle;
  logic [COUNT_W-1:0]  out_tick_count;
  int                  mismatch_count;
  int                  results_owed;

  int send_pct;
  int recv_pct;
  int hold_req;

  always #5 clk = ~clk;

  tick_priority_scheduler_top u_top (.*);

  tps_checker u_checker (.*);

  // Result side: random stall, plus one long hold-off on request
  initial begin : result_receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  // Offer one item, with random gaps first; return once it has been transferred
  task automatic send_item(kind_t k, logic [PROC_W-1:0] p, logic b,
                           logic [PVAL_W-1:0] v, logic n);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_kind           <= k;
    in_process        <= p;
    in_blocked        <= b;
    in_priority_value <= v;
    in_nested         <= n;
    do @(posedge clk); while (in_stall);
  endtask

  // Mostly ticks against small priorities so budgets run out often
  task automatic send_random();
    int r;
    kind_t k;
    logic [PVAL_W-1:0] v;
    r = $urandom_range(99);
    if (r < 60)      k = KIND_TICK;
    else if (r < 72) k = KIND_PRIORITY;
    else if (r < 85) k = KIND_BLOCK;
    else             k = KIND_RESCHED;
    v = ($urandom_range(9) == 0) ? PVAL_W'($urandom_range(255)) : PVAL_W'($urandom_range(12));
    send_item(k, PROC_W'($urandom_range(7)), ($urandom_range(99) < 35), v,
              ($urandom_range(4) == 0));
  endtask

  // Hold the input idle until every predicted result has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  initial begin : stimulus
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_kind           = KIND_TICK;
    in_process        = '0;
    in_blocked        = 1'b0;
    in_priority_value = '0;
    in_nested         = 1'b0;
    send_pct          = 0;
    recv_pct          = 0;
    hold_req          = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, nested and plain ticks with nothing to run
    send_item(KIND_RESCHED, 3'd0, 1'b0, 8'd0, 1'b0);
    send_item(KIND_TICK, 3'd0, 1'b0, 8'd0, 1'b1);
    send_item(KIND_TICK, 3'd0, 1'b0, 8'd0, 1'b0);
    // Fill the table: widest priority, zero priority, a tie and a small one
    send_item(KIND_PRIORITY, 3'd7, 1'b0, 8'd255, 1'b0);
    send_item(KIND_PRIORITY, 3'd0, 1'b0, 8'd0, 1'b0);
    send_item(KIND_PRIORITY, 3'd3, 1'b0, 8'd3, 1'b0);
    send_item(KIND_PRIORITY, 3'd5, 1'b0, 8'd3, 1'b0);
    send_item(KIND_PRIORITY, 3'd2, 1'b0, 8'd1, 1'b0);
    send_item(KIND_RESCHED, 3'd0, 1'b0, 8'd0, 1'b0);
    // Blocked running process still loses a tick
    send_item(KIND_BLOCK, 3'd7, 1'b1, 8'd0, 1'b0);
    send_item(KIND_TICK, 3'd0, 1'b0, 8'd0, 1'b0);
    // Tie goes to the lower index
    send_item(KIND_RESCHED, 3'd0, 1'b0, 8'd0, 1'b0);
    // Nested ticks drain the budget without a switch
    repeat (3) send_item(KIND_TICK, 3'd0, 1'b0, 8'd0, 1'b1);
    // Plain ticks: switch on spent budget, then refill once all are spent
    repeat (6) send_item(KIND_TICK, 3'd0, 1'b0, 8'd0, 1'b0);
    // Block every process with a priority: nothing left to run
    send_item(KIND_BLOCK, 3'd2, 1'b1, 8'd0, 1'b0);
    send_item(KIND_BLOCK, 3'd3, 1'b1, 8'd0, 1'b0);
    send_item(KIND_BLOCK, 3'd5, 1'b1, 8'd0, 1'b0);
    send_item(KIND_RESCHED, 3'd0, 1'b0, 8'd0, 1'b0);
    send_item(KIND_BLOCK, 3'd7, 1'b0, 8'd0, 1'b0);

    // Random: sender gaps light, receiver stalls heavy
    send_pct = 29;
    recv_pct <= 68;
    repeat (PHASE_ITEMS) send_random();

    // Long hold-off on the result side while items keep coming
    send_pct = 0;
    hold_req <= hold_req + 1;
    repeat (20) send_random();
    wait_drained();

    // Random: the other way round
    send_pct = 68;
    recv_pct <= 29;
    repeat (PHASE_ITEMS) send_random();

    // Random: no idling on either side
    send_pct = 0;
    recv_pct <= 0;
    repeat (PHASE_ITEMS) send_random();

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
